### rtl/assert_macros.svh
// Assertion macros shared by the RTL of the accumulator ALU block.
// No dependencies; the bodies drop out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset
`define ACC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition never holds outside reset
`define ACC_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ACC_ASSERT(lbl, clk, rst_n, prop, msg)
`define ACC_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

### rtl/accalu_pkg.sv
// Types, opcodes and flag constants for the accumulator ALU block.
// No dependencies; used by the channel interfaces and the top level.
package accalu_pkg;

    // Input item: opcode, second byte and the memory byte fetched outside
    typedef struct packed {
        logic [7:0] kind;
        logic [7:0] immediate_byte;
        logic [7:0] mem_read_data;
    } t_in_item;

    // Result item: architectural view after one instruction
    typedef struct packed {
        logic [7:0]  accumulator;
        logic [7:0]  flag_byte;
        logic        mem_write;
        logic [15:0] mem_address;
        logic [7:0]  mem_write_data;
        logic [15:0] pair_bc;
        logic [15:0] pair_de;
        logic [15:0] pair_hl;
        logic        unimplemented;
    } t_out_item;

    // General registers
    typedef struct packed {
        logic [7:0] b;
        logic [7:0] c;
        logic [7:0] d;
        logic [7:0] e;
        logic [7:0] h;
        logic [7:0] l;
        logic [7:0] a;
    } t_regs;

    // ALU group operation, opcode bits 5:3 in the range 0x80 to 0xbf
    typedef enum logic [2:0] {
        ALU_ADD = 3'd0,
        ALU_ADC = 3'd1,
        ALU_SUB = 3'd2,
        ALU_SBB = 3'd3,
        ALU_ANA = 3'd4,
        ALU_XRA = 3'd5,
        ALU_ORA = 3'd6,
        ALU_CMP = 3'd7
    } t_alu_op;

    // Register codes inside an opcode
    localparam logic [2:0] CODE_B = 3'd0;
    localparam logic [2:0] CODE_C = 3'd1;
    localparam logic [2:0] CODE_D = 3'd2;
    localparam logic [2:0] CODE_E = 3'd3;
    localparam logic [2:0] CODE_H = 3'd4;
    localparam logic [2:0] CODE_L = 3'd5;
    localparam logic [2:0] CODE_M = 3'd6;
    localparam logic [2:0] CODE_A = 3'd7;

    // Opcode groups (bits 7:6) and low-field codes
    localparam logic [1:0] GRP_MISC = 2'b00;
    localparam logic [1:0] GRP_MOV  = 2'b01;
    localparam logic [1:0] GRP_ALU  = 2'b10;
    localparam logic [2:0] LOW_INR  = 3'd4;
    localparam logic [2:0] LOW_DCR  = 3'd5;
    localparam logic [2:0] LOW_MVI  = 3'd6;

    // Single opcodes
    localparam logic [7:0] OP_STAX_B = 8'h02;
    localparam logic [7:0] OP_RLC    = 8'h07;
    localparam logic [7:0] OP_LDAX_B = 8'h0a;
    localparam logic [7:0] OP_RRC    = 8'h0f;
    localparam logic [7:0] OP_STAX_D = 8'h12;
    localparam logic [7:0] OP_LDAX_D = 8'h1a;
    localparam logic [7:0] OP_DAA    = 8'h27;
    localparam logic [7:0] OP_CMA    = 8'h2f;
    localparam logic [7:0] OP_STC    = 8'h37;
    localparam logic [7:0] OP_CMC    = 8'h3f;
    localparam logic [7:0] OP_HLT    = 8'h76;
    localparam logic [7:0] OP_ADI    = 8'hc6;

    // Flag bit positions and fixed format
    localparam logic [2:0] FLAG_S  = 3'd7;
    localparam logic [2:0] FLAG_Z  = 3'd6;
    localparam logic [2:0] FLAG_AC = 3'd4;
    localparam logic [2:0] FLAG_P  = 3'd2;
    localparam logic [2:0] FLAG_CY = 3'd0;
    localparam logic [7:0] FLAG_KEEP_MASK   = 8'hd5;
    localparam logic [7:0] FLAG_FIXED_ONE   = 8'h02;
    localparam logic [7:0] FLAG_FORMAT_MASK = 8'h2a;
    localparam logic [7:0] FLAG_RESET       = 8'h02;

    // Decimal adjust constants
    localparam logic [3:0] BCD_MAX_DIGIT = 4'd9;
    localparam logic [3:0] DAA_LOW_CORR  = 4'h6;
    localparam logic [3:0] DAA_HIGH_CORR = 4'h6;

endpackage

### rtl/accalu_ifs.sv
// Valid/ready channel interfaces for input items and result items.
// Depends on accalu_pkg for the payload types.
interface accalu_in_if;
    import accalu_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface accalu_out_if;
    import accalu_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/accumulator_alu_with_flags.sv
// Top level of the accumulator ALU: registers B..L, A, flags and the execute logic.
// Depends on accalu_pkg, the channel interfaces in accalu_ifs.sv and assert_macros.svh.
//
// Usage:
//   i_in carries one instruction per item: opcode, immediate byte and the memory
//   byte at the address the opcode names. o_out returns one result item per
//   input item: A, flags, register pairs and an optional memory write.
//   An item moves on a rising edge with valid and ready both high.
//   An accepted item is held in the input register; the execute logic then
//   writes the state and the result register when the result register is free
//   or being taken. Throughput is one item per cycle while the receiver does not
//   stall; the state update of one item completes in the cycle it executes, so
//   the next item sees it at once.
//   When the receiver stalls, the result register holds and the input register
//   fills; i_in.ready drops only when both are full and o_out.ready is low.
//   Reset (synchronous, active low) clears all general registers to zero, sets
//   the flag byte to 0x02 and empties both stages; an item offered while i_rst_n
//   is low is dropped, even though i_in.ready may be high.
`include "assert_macros.svh"

module accumulator_alu_with_flags (
    input  logic               i_clk,
    input  logic               i_rst_n,
    accalu_in_if.sink          i_in,
    accalu_out_if.source       o_out
);
    import accalu_pkg::*;

    // Read a register by opcode code; code M reads the memory byte
    function automatic logic [7:0] reg_read(input t_regs regs, input logic [2:0] code,
                                            input logic [7:0] mem);
        logic [7:0] val;
        begin
            unique case (code)
                CODE_B:  val = regs.b;
                CODE_C:  val = regs.c;
                CODE_D:  val = regs.d;
                CODE_E:  val = regs.e;
                CODE_H:  val = regs.h;
                CODE_L:  val = regs.l;
                CODE_M:  val = mem;
                CODE_A:  val = regs.a;
                default: val = regs.a;
            endcase
            return val;
        end
    endfunction

    // Write a register by opcode code; code M leaves the registers alone
    function automatic t_regs reg_write(input t_regs regs, input logic [2:0] code,
                                        input logic [7:0] val);
        t_regs res;
        begin
            res = regs;
            unique case (code)
                CODE_B:  res.b = val;
                CODE_C:  res.c = val;
                CODE_D:  res.d = val;
                CODE_E:  res.e = val;
                CODE_H:  res.h = val;
                CODE_L:  res.l = val;
                CODE_M:  res = regs;
                CODE_A:  res.a = val;
                default: res = regs;
            endcase
            return res;
        end
    endfunction

    // Set sign, zero and parity from a result byte
    function automatic logic [7:0] set_szp(input logic [7:0] flags, input logic [7:0] r);
        logic [7:0] res;
        begin
            res = flags;
            res[FLAG_S] = r[7];
            res[FLAG_Z] = (r == 8'h00);
            res[FLAG_P] = ~(^r);
            return res;
        end
    endfunction

    // Pipeline control
    logic      r_s1_valid;
    t_in_item  r_s1_data;
    logic      r_out_valid;
    t_out_item r_out_data;
    logic      advance;
    logic      s1_fire;

    // Architectural state
    t_regs      r_regs;
    logic [7:0] r_flags;
    t_regs      n_regs;
    logic [7:0] n_flags;
    t_out_item  n_out;

    // Execute datapath
    logic [7:0] k;
    logic [7:0] a;
    logic [7:0] md;
    logic [7:0] imm;
    logic [2:0] src;
    logic [2:0] dst;
    logic       cy;
    logic [7:0] v;
    t_alu_op    alu_op;
    logic [7:0] add_b;
    logic       add_cin;
    logic       add_sub;
    logic [8:0] sum;
    logic [4:0] nib_sum;
    logic       add_cy;
    logic       add_ac;
    logic [7:0] old;
    logic [7:0] incdec;
    logic       incdec_ac;
    logic       daa_lo_fix;
    logic       daa_hi_fix;
    logic [7:0] daa_corr;
    logic [7:0] daa_res;
    logic [4:0] daa_nib;
    logic [7:0] logic_res;
    logic [15:0] hl;
    logic       mw;
    logic [15:0] addr;
    logic [7:0] wd;
    logic       unimpl;

    // Advance the execute stage when the result register is free or being taken
    assign advance    = !r_out_valid || o_out.ready;
    assign s1_fire    = r_s1_valid && advance;
    assign i_in.ready = !r_s1_valid || advance;

    // Operand fetch, adder and special units
    always_comb begin
        k       = r_s1_data.kind;
        imm     = r_s1_data.immediate_byte;
        md      = r_s1_data.mem_read_data;
        a       = r_regs.a;
        src     = k[2:0];
        dst     = k[5:3];
        cy      = r_flags[FLAG_CY];
        hl      = {r_regs.h, r_regs.l};
        v       = reg_read(r_regs, src, md);
        alu_op  = t_alu_op'(dst);

        // Select adder operands: subtract forms add the complement
        if (k == OP_ADI) begin
            add_b   = imm;
            add_cin = 1'b0;
            add_sub = 1'b0;
        end else begin
            unique case (alu_op) inside
                ALU_ADD, ALU_ANA, ALU_XRA, ALU_ORA: begin
                    add_b   = v;
                    add_cin = 1'b0;
                    add_sub = 1'b0;
                end
                ALU_ADC: begin
                    add_b   = v;
                    add_cin = cy;
                    add_sub = 1'b0;
                end
                ALU_SUB, ALU_CMP: begin
                    add_b   = ~v;
                    add_cin = 1'b1;
                    add_sub = 1'b1;
                end
                ALU_SBB: begin
                    add_b   = ~v;
                    add_cin = ~cy;
                    add_sub = 1'b1;
                end
                default: begin
                    add_b   = v;
                    add_cin = 1'b0;
                    add_sub = 1'b0;
                end
            endcase
        end
        sum     = {1'b0, a} + {1'b0, add_b} + {8'd0, add_cin};
        nib_sum = {1'b0, a[3:0]} + {1'b0, add_b[3:0]} + {4'd0, add_cin};
        add_cy  = sum[8] ^ add_sub;
        add_ac  = nib_sum[4];

        // Increment or decrement of a register or the memory byte
        old = reg_read(r_regs, dst, md);
        if (src == LOW_INR) begin
            incdec    = old + 8'd1;
            incdec_ac = (incdec[3:0] == 4'h0);
        end else begin
            incdec    = old - 8'd1;
            incdec_ac = (old[3:0] != 4'h0);
        end

        // Decimal adjust of A
        daa_lo_fix = r_flags[FLAG_AC] || (a[3:0] > BCD_MAX_DIGIT);
        daa_hi_fix = cy || (a[7:4] > BCD_MAX_DIGIT)
                     || ((a[7:4] >= BCD_MAX_DIGIT) && (a[3:0] > BCD_MAX_DIGIT));
        daa_corr   = {daa_hi_fix ? DAA_HIGH_CORR : 4'h0, daa_lo_fix ? DAA_LOW_CORR : 4'h0};
        daa_nib    = {1'b0, a[3:0]} + {1'b0, daa_corr[3:0]};
        daa_res    = a + daa_corr;

        // Logic group result
        unique case (alu_op) inside
            ALU_ANA: logic_res = a & v;
            ALU_XRA: logic_res = a ^ v;
            ALU_ORA: logic_res = a | v;
            default: logic_res = sum[7:0];
        endcase
    end

    // Decode and next state
    always_comb begin
        n_regs  = r_regs;
        n_flags = r_flags;
        mw      = 1'b0;
        addr    = 16'h0000;
        wd      = 8'h00;
        unimpl  = 1'b0;

        if ((k[7:6] == GRP_MOV) && (k != OP_HLT)) begin
            // Move: destination M stores to HL
            if (dst == CODE_M) begin
                mw   = 1'b1;
                addr = hl;
                wd   = v;
            end else begin
                n_regs = reg_write(r_regs, dst, v);
            end
        end else if (k[7:6] == GRP_ALU) begin
            unique case (alu_op) inside
                ALU_ADD, ALU_ADC, ALU_SUB, ALU_SBB: begin
                    n_regs.a         = sum[7:0];
                    n_flags          = set_szp(r_flags, sum[7:0]);
                    n_flags[FLAG_AC] = add_ac;
                    n_flags[FLAG_CY] = add_cy;
                end
                ALU_CMP: begin
                    n_flags          = set_szp(r_flags, sum[7:0]);
                    n_flags[FLAG_AC] = add_ac;
                    n_flags[FLAG_CY] = add_cy;
                end
                ALU_ANA: begin
                    n_regs.a         = logic_res;
                    n_flags          = set_szp(r_flags, logic_res);
                    n_flags[FLAG_AC] = a[3] | v[3];
                    n_flags[FLAG_CY] = 1'b0;
                end
                ALU_XRA, ALU_ORA: begin
                    n_regs.a         = logic_res;
                    n_flags          = set_szp(r_flags, logic_res);
                    n_flags[FLAG_AC] = 1'b0;
                    n_flags[FLAG_CY] = 1'b0;
                end
                default: begin
                    n_regs = r_regs;
                end
            endcase
        end else if ((k[7:6] == GRP_MISC) && ((src == LOW_INR) || (src == LOW_DCR))) begin
            // Increment or decrement; carry holds
            n_flags          = set_szp(r_flags, incdec);
            n_flags[FLAG_AC] = incdec_ac;
            if (dst == CODE_M) begin
                mw   = 1'b1;
                addr = hl;
                wd   = incdec;
            end else begin
                n_regs = reg_write(r_regs, dst, incdec);
            end
        end else if ((k[7:6] == GRP_MISC) && (src == LOW_MVI)) begin
            if (dst == CODE_M) begin
                mw   = 1'b1;
                addr = hl;
                wd   = imm;
            end else begin
                n_regs = reg_write(r_regs, dst, imm);
            end
        end else if (k == OP_ADI) begin
            n_regs.a         = sum[7:0];
            n_flags          = set_szp(r_flags, sum[7:0]);
            n_flags[FLAG_AC] = add_ac;
            n_flags[FLAG_CY] = add_cy;
        end else if ((k == OP_STAX_B) || (k == OP_STAX_D)) begin
            mw   = 1'b1;
            addr = (k == OP_STAX_B) ? {r_regs.b, r_regs.c} : {r_regs.d, r_regs.e};
            wd   = a;
        end else if ((k == OP_LDAX_B) || (k == OP_LDAX_D)) begin
            n_regs.a = md;
        end else if (k == OP_RLC) begin
            n_regs.a         = {a[6:0], a[7]};
            n_flags[FLAG_CY] = a[7];
        end else if (k == OP_RRC) begin
            n_regs.a         = {a[0], a[7:1]};
            n_flags[FLAG_CY] = a[0];
        end else if (k == OP_DAA) begin
            n_regs.a         = daa_res;
            n_flags          = set_szp(r_flags, daa_res);
            n_flags[FLAG_AC] = daa_nib[4];
            n_flags[FLAG_CY] = cy | daa_hi_fix;
        end else if (k == OP_CMA) begin
            n_regs.a = ~a;
        end else if (k == OP_STC) begin
            n_flags[FLAG_CY] = 1'b1;
        end else if (k == OP_CMC) begin
            n_flags[FLAG_CY] = ~cy;
        end else begin
            unimpl = 1'b1;
        end

        // Force the fixed flag bits
        n_flags = (n_flags & FLAG_KEEP_MASK) | FLAG_FIXED_ONE;

        n_out.accumulator    = n_regs.a;
        n_out.flag_byte      = n_flags;
        n_out.mem_write      = mw;
        n_out.mem_address    = addr;
        n_out.mem_write_data = wd;
        n_out.pair_bc        = {n_regs.b, n_regs.c};
        n_out.pair_de        = {n_regs.d, n_regs.e};
        n_out.pair_hl        = {n_regs.h, n_regs.l};
        n_out.unimplemented  = unimpl;
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_s1_data <= i_in.data;
        end
    end

    // Commit state and load the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs      <= '0;
            r_flags     <= FLAG_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid <= r_s1_valid;
            end
            if (s1_fire) begin
                r_regs  <= n_regs;
                r_flags <= n_flags;
            end
        end
        if (s1_fire) begin
            r_out_data <= n_out;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    // Checks
    `ACC_ASSERT(a_flag_format, i_clk, i_rst_n,
        (r_flags & FLAG_FORMAT_MASK) == FLAG_FIXED_ONE, "flag byte has a fixed bit wrong")
    `ACC_ASSERT(a_exec_loads_result, i_clk, i_rst_n,
        s1_fire |=> r_out_valid, "executed item did not reach the result register")
    `ACC_ASSERT(a_unimpl_no_effect, i_clk, i_rst_n,
        (s1_fire && unimpl) |=> ((r_regs == $past(r_regs)) && (r_flags == $past(r_flags))),
        "unimplemented opcode changed state")
    `ACC_ASSERT_NEVER(a_no_write_clean, i_clk, i_rst_n,
        r_out_valid && !r_out_data.mem_write
            && ((r_out_data.mem_address != 16'h0000) || (r_out_data.mem_write_data != 8'h00)),
        "store fields set without a memory write")
    `ACC_ASSERT(a_ready_when_empty, i_clk, i_rst_n,
        !r_out_valid |-> i_in.ready, "input stalled with an empty result register")

endmodule

### dv/accumulator_alu_with_flags_test.sv
// Self-checking testbench for accumulator_alu_with_flags: a directed table, then random opcodes.
// Depends on accalu_pkg, the channel interfaces in accalu_ifs.sv and the block's top level.
// A local instruction-level predictor computes each expected result item; mismatches are counted.
module accumulator_alu_with_flags_test;
    import accalu_pkg::*;

    localparam logic [7:0] OP_NOP      = 8'h00;
    localparam int         SLOT_A      = 6;
    localparam int         RANDOM_ITEMS = 1820;
    localparam int         STALL_LIMIT = 2000;
    localparam int         DRAIN_CYCLES = 8;
    localparam int         HOLD_CYCLES = 80;
    localparam int         SHOWN_MISMATCHES = 10;

    // One row of the directed table; want is used only where typed is set
    typedef struct packed {
        t_in_item  stim;
        logic      typed;
        t_out_item want;
    } t_dir_row;

    localparam int DIR_ROWS = 31;

    logic i_clk;
    logic i_rst_n;

    accalu_in_if  in_ch ();
    accalu_out_if out_ch ();

    accumulator_alu_with_flags dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Predictor state: B, C, D, E, H, L, A and the flag byte
    logic [7:0] model_regs [0:6];
    logic [7:0] model_flags;

    t_out_item  expected_results [$];
    int         mismatches;
    int         results_seen;
    logic       steady_phase;
    logic       hold_request;

    // Directed items: extremes, every operation, unlisted opcodes, ignored memory bytes
    t_dir_row dir_rows [DIR_ROWS] = '{
        // after reset: nothing executes, flags at their reset value
        '{'{OP_NOP, 8'h00, 8'h00}, 1'b1,
          '{accumulator: 8'h00, flag_byte: FLAG_RESET, unimplemented: 1'b1, default: '0}},
        '{'{{GRP_MISC, CODE_A, LOW_MVI}, 8'hff, 8'h00}, 1'b1,
          '{accumulator: 8'hff, flag_byte: FLAG_RESET, default: '0}},
        // 0xff + 1: zero, carry, aux carry, even parity
        '{'{OP_ADI, 8'h01, 8'h00}, 1'b1,
          '{accumulator: 8'h00, flag_byte: 8'h57, default: '0}},
        '{'{{GRP_MISC, CODE_B, LOW_MVI}, 8'h80, 8'h00}, 1'b0, '0},
        '{'{{GRP_MISC, CODE_C, LOW_MVI}, 8'hff, 8'h00}, 1'b0, '0},
        '{'{{GRP_MISC, CODE_D, LOW_MVI}, 8'h00, 8'hff}, 1'b0, '0},
        '{'{{GRP_MISC, CODE_H, LOW_MVI}, 8'hff, 8'h00}, 1'b0, '0},
        '{'{{GRP_MISC, CODE_L, LOW_MVI}, 8'hfe, 8'h00}, 1'b0, '0},
        '{'{{GRP_MISC, CODE_M, LOW_MVI}, 8'ha5, 8'h00}, 1'b0, '0},
        '{'{{GRP_MOV, CODE_A, CODE_B}, 8'h00, 8'h5a}, 1'b0, '0},
        '{'{{GRP_MOV, CODE_M, CODE_A}, 8'h00, 8'h00}, 1'b0, '0},
        '{'{{GRP_MOV, CODE_B, CODE_M}, 8'h00, 8'hff}, 1'b0, '0},
        '{'{{GRP_MISC, CODE_M, LOW_INR}, 8'h00, 8'hff}, 1'b0, '0},
        '{'{{GRP_MISC, CODE_D, LOW_DCR}, 8'h00, 8'h00}, 1'b0, '0},
        '{'{{GRP_ALU, ALU_ADD, CODE_B}, 8'h00, 8'hff}, 1'b0, '0},
        '{'{{GRP_ALU, ALU_ADC, CODE_M}, 8'h00, 8'hff}, 1'b0, '0},
        '{'{{GRP_ALU, ALU_SUB, CODE_C}, 8'h00, 8'h00}, 1'b0, '0},
        '{'{{GRP_ALU, ALU_SBB, CODE_A}, 8'h00, 8'h00}, 1'b0, '0},
        '{'{{GRP_ALU, ALU_ANA, CODE_H}, 8'h00, 8'h00}, 1'b0, '0},
        '{'{{GRP_ALU, ALU_XRA, CODE_M}, 8'h00, 8'h0f}, 1'b0, '0},
        '{'{{GRP_ALU, ALU_ORA, CODE_L}, 8'h00, 8'h00}, 1'b0, '0},
        '{'{{GRP_ALU, ALU_CMP, CODE_M}, 8'h00, 8'h80}, 1'b0, '0},
        '{'{OP_STAX_B, 8'h00, 8'h00}, 1'b0, '0},
        '{'{OP_LDAX_B, 8'h00, 8'h99}, 1'b0, '0},
        '{'{OP_DAA, 8'h00, 8'h00}, 1'b0, '0},
        '{'{OP_CMA, 8'h00, 8'h00}, 1'b0, '0},
        '{'{OP_STC, 8'h00, 8'h00}, 1'b0, '0},
        '{'{OP_CMC, 8'h00, 8'h00}, 1'b0, '0},
        '{'{OP_RLC, 8'h00, 8'h00}, 1'b0, '0},
        '{'{OP_RRC, 8'h00, 8'h00}, 1'b0, '0},
        '{'{OP_HLT, 8'hff, 8'hff}, 1'b0, '0}
    };

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Map a register code to its slot; the accumulator sits after L
    function automatic int reg_slot(logic [2:0] code);
        return (code == CODE_A) ? SLOT_A : int'(code);
    endfunction

    // Update sign, zero and parity from a result byte
    function automatic logic [7:0] with_szp(logic [7:0] f, logic [7:0] r);
        f[FLAG_S] = r[7];
        f[FLAG_Z] = (r == 8'h00);
        f[FLAG_P] = ~^r;
        return f;
    endfunction

    // Add with carry in; carry and aux carry are true carries
    function automatic logic [7:0] add_bytes(input logic [7:0] a, input logic [7:0] b,
                                             input logic cin, inout logic [7:0] f);
        logic [8:0] sum;
        logic [4:0] nib;
        sum = {1'b0, a} + {1'b0, b} + 9'(cin);
        nib = {1'b0, a[3:0]} + {1'b0, b[3:0]} + 5'(cin);
        f[FLAG_AC] = nib[4];
        f[FLAG_CY] = sum[8];
        f = with_szp(f, sum[7:0]);
        return sum[7:0];
    endfunction

    // Subtract with borrow in; carry ends up as borrow
    function automatic logic [7:0] sub_bytes(input logic [7:0] a, input logic [7:0] b,
                                             input logic bin, inout logic [7:0] f);
        logic [7:0] diff;
        diff = add_bytes(a, ~b, ~bin, f);
        f[FLAG_CY] = ~f[FLAG_CY];
        return diff;
    endfunction

    // Execute one instruction on the predictor state and build its result item
    function automatic t_out_item execute_opcode(t_in_item it);
        t_out_item  res;
        logic [7:0] k, a, f, v, old, r, corr;
        logic [2:0] src, dst;
        logic [3:0] lo, hi;
        logic [4:0] nib;
        logic [15:0] hl, bc, de;
        logic       cy, ncy;
        res = '0;
        k   = it.kind;
        src = k[2:0];
        dst = k[5:3];
        a   = model_regs[SLOT_A];
        f   = model_flags;
        cy  = model_flags[FLAG_CY];
        hl  = {model_regs[CODE_H], model_regs[CODE_L]};
        bc  = {model_regs[CODE_B], model_regs[CODE_C]};
        de  = {model_regs[CODE_D], model_regs[CODE_E]};
        v   = (src == CODE_M) ? it.mem_read_data : model_regs[reg_slot(src)];

        if (k[7:6] == GRP_MOV && k != OP_HLT) begin
            if (dst == CODE_M) begin
                res.mem_write      = 1'b1;
                res.mem_address    = hl;
                res.mem_write_data = v;
            end else begin
                model_regs[reg_slot(dst)] = v;
            end
        end else if (k[7:6] == GRP_ALU) begin
            case (t_alu_op'(dst))
                ALU_ADD: a = add_bytes(a, v, 1'b0, f);
                ALU_ADC: a = add_bytes(a, v, cy, f);
                ALU_SUB: a = sub_bytes(a, v, 1'b0, f);
                ALU_SBB: a = sub_bytes(a, v, cy, f);
                ALU_ANA: begin
                    f[FLAG_AC] = a[3] | v[3];
                    a = a & v;
                    f[FLAG_CY] = 1'b0;
                    f = with_szp(f, a);
                end
                ALU_XRA: begin
                    a = a ^ v;
                    f[FLAG_AC] = 1'b0;
                    f[FLAG_CY] = 1'b0;
                    f = with_szp(f, a);
                end
                ALU_ORA: begin
                    a = a | v;
                    f[FLAG_AC] = 1'b0;
                    f[FLAG_CY] = 1'b0;
                    f = with_szp(f, a);
                end
                default: r = sub_bytes(a, v, 1'b0, f);
            endcase
            model_regs[SLOT_A] = a;
        end else if (k[7:6] == GRP_MISC && (src == LOW_INR || src == LOW_DCR)) begin
            // Increment and decrement keep the carry
            old = (dst == CODE_M) ? it.mem_read_data : model_regs[reg_slot(dst)];
            if (src == LOW_INR) begin
                r = old + 8'h01;
                f[FLAG_AC] = (r[3:0] == 4'h0);
            end else begin
                r = old - 8'h01;
                f[FLAG_AC] = (old[3:0] != 4'h0);
            end
            f = with_szp(f, r);
            if (dst == CODE_M) begin
                res.mem_write      = 1'b1;
                res.mem_address    = hl;
                res.mem_write_data = r;
            end else begin
                model_regs[reg_slot(dst)] = r;
            end
        end else if (k[7:6] == GRP_MISC && src == LOW_MVI) begin
            if (dst == CODE_M) begin
                res.mem_write      = 1'b1;
                res.mem_address    = hl;
                res.mem_write_data = it.immediate_byte;
            end else begin
                model_regs[reg_slot(dst)] = it.immediate_byte;
            end
        end else if (k == OP_ADI) begin
            model_regs[SLOT_A] = add_bytes(a, it.immediate_byte, 1'b0, f);
        end else if (k == OP_STAX_B || k == OP_STAX_D) begin
            res.mem_write      = 1'b1;
            res.mem_address    = (k == OP_STAX_B) ? bc : de;
            res.mem_write_data = a;
        end else if (k == OP_LDAX_B || k == OP_LDAX_D) begin
            model_regs[SLOT_A] = it.mem_read_data;
        end else if (k == OP_RLC) begin
            f[FLAG_CY] = a[7];
            model_regs[SLOT_A] = {a[6:0], a[7]};
        end else if (k == OP_RRC) begin
            f[FLAG_CY] = a[0];
            model_regs[SLOT_A] = {a[0], a[7:1]};
        end else if (k == OP_DAA) begin
            // Decimal adjust: low correction on aux carry or digit above nine
            lo   = a[3:0];
            hi   = a[7:4];
            corr = 8'h00;
            ncy  = cy;
            if (f[FLAG_AC] || lo > BCD_MAX_DIGIT)
                corr[3:0] = DAA_LOW_CORR;
            if (cy || hi > BCD_MAX_DIGIT || (hi >= BCD_MAX_DIGIT && lo > BCD_MAX_DIGIT)) begin
                corr[7:4] = DAA_HIGH_CORR;
                ncy = 1'b1;
            end
            nib = {1'b0, lo} + {1'b0, corr[3:0]};
            f[FLAG_AC] = nib[4];
            a = a + corr;
            f = with_szp(f, a);
            f[FLAG_CY] = ncy;
            model_regs[SLOT_A] = a;
        end else if (k == OP_CMA) begin
            model_regs[SLOT_A] = ~a;
        end else if (k == OP_STC) begin
            f[FLAG_CY] = 1'b1;
        end else if (k == OP_CMC) begin
            f[FLAG_CY] = ~f[FLAG_CY];
        end else begin
            res.unimplemented = 1'b1;
        end

        // Force the fixed flag bits
        model_flags       = (f & FLAG_KEEP_MASK) | FLAG_FIXED_ONE;
        res.accumulator   = model_regs[SLOT_A];
        res.flag_byte     = model_flags;
        res.pair_bc       = {model_regs[CODE_B], model_regs[CODE_C]};
        res.pair_de       = {model_regs[CODE_D], model_regs[CODE_E]};
        res.pair_hl       = {model_regs[CODE_H], model_regs[CODE_L]};
        return res;
    endfunction

    // Draw a random instruction, mostly executable opcodes
    function automatic t_in_item random_instruction();
        t_in_item   it;
        logic [2:0] hi3, lo3;
        int         pick;
        pick = $urandom_range(0, 99);
        hi3  = 3'($urandom_range(0, 7));
        lo3  = 3'($urandom_range(0, 7));
        it.immediate_byte = 8'($urandom_range(0, 255));
        it.mem_read_data  = 8'($urandom_range(0, 255));
        if (pick < 20) begin
            it.kind = 8'($urandom_range(0, 255));
        end else if (pick < 40) begin
            it.kind = {GRP_MOV, hi3, lo3};
        end else if (pick < 65) begin
            it.kind = {GRP_ALU, hi3, lo3};
        end else if (pick < 80) begin
            case ($urandom_range(0, 2))
                0:       it.kind = {GRP_MISC, hi3, LOW_INR};
                1:       it.kind = {GRP_MISC, hi3, LOW_DCR};
                default: it.kind = {GRP_MISC, hi3, LOW_MVI};
            endcase
        end else begin
            case ($urandom_range(0, 10))
                0:       it.kind = OP_ADI;
                1:       it.kind = OP_STAX_B;
                2:       it.kind = OP_STAX_D;
                3:       it.kind = OP_LDAX_B;
                4:       it.kind = OP_LDAX_D;
                5:       it.kind = OP_RLC;
                6:       it.kind = OP_RRC;
                7:       it.kind = OP_DAA;
                8:       it.kind = OP_CMA;
                9:       it.kind = OP_STC;
                default: it.kind = OP_CMC;
            endcase
        end
        return it;
    endfunction

    // Offer one item, wait for it to be taken, then queue its expected result
    task automatic send_instruction(input t_in_item it, input logic typed, input t_out_item want);
        t_out_item predicted;
        if (!steady_phase && $urandom_range(0, 99) < 25) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predicted = execute_opcode(it);
        expected_results.push_back(typed ? want : predicted);
    endtask

    // Hold off the sender until every queued result has come back
    task automatic wait_results_drained();
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    // Compare one field and report the first few mismatches
    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= SHOWN_MISMATCHES)
                $display("result %0d %s: expected %h, got %h", results_seen, name, want, got);
        end
    endtask

    // Stimulus: reset, directed table, random items, drain and verdict
    initial begin
        int i;
        mismatches    = 0;
        results_seen  = 0;
        steady_phase  = 1'b0;
        hold_request  = 1'b0;
        i_rst_n      <= 1'b0;
        in_ch.valid  <= 1'b0;
        in_ch.data   <= '0;
        for (i = 0; i < 7; i++) model_regs[i] = 8'h00;
        model_flags = FLAG_RESET;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < DIR_ROWS; i++)
            send_instruction(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);
        wait_results_drained();

        for (i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == 400) hold_request <= 1'b1;
            if (i == 700) wait_results_drained();
            if (i == 1000) steady_phase <= 1'b1;
            if (i == 1200) steady_phase <= 1'b0;
            send_instruction(random_instruction(), 1'b0, '0);
        end
        in_ch.valid <= 1'b0;

        // Let the pipeline empty, then watch for stray results
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("accumulator_alu_with_flags verification clean");
        else
            $display("accumulator_alu_with_flags verification failed");
        $finish;
    end

    // Receiver: random stalls, one long hold-off, no stalls in the steady phase
    initial begin
        int   hold_left;
        logic hold_taken;
        hold_left   = 0;
        hold_taken  = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (!i_rst_n) begin
                out_ch.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (steady_phase) begin
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= 25);
            end
        end
    end

    // Result checker: compare each taken result item with the oldest expectation
    initial begin
        t_out_item want;
        forever begin
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= SHOWN_MISMATCHES)
                        $display("result %0d arrived with nothing expected", results_seen);
                end else begin
                    want = expected_results.pop_front();
                    check_field("accumulator", 16'(out_ch.data.accumulator), 16'(want.accumulator));
                    check_field("flag_byte", 16'(out_ch.data.flag_byte), 16'(want.flag_byte));
                    check_field("mem_write", 16'(out_ch.data.mem_write), 16'(want.mem_write));
                    check_field("mem_address", out_ch.data.mem_address, want.mem_address);
                    check_field("mem_write_data", 16'(out_ch.data.mem_write_data),
                                16'(want.mem_write_data));
                    check_field("pair_bc", out_ch.data.pair_bc, want.pair_bc);
                    check_field("pair_de", out_ch.data.pair_de, want.pair_de);
                    check_field("pair_hl", out_ch.data.pair_hl, want.pair_hl);
                    check_field("unimplemented", 16'(out_ch.data.unimplemented),
                                16'(want.unimplemented));
                end
            end
        end
    end

    // Watchdog: end the run after too many cycles without any item moving
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("accumulator_alu_with_flags verification failed");
        $finish;
    end

endmodule
